/* src/xtea128_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// xtea128_pkg
// Types, constants and codes shared by the 128-bit XTEA block cipher files.
// ----------------------------------------------------------------------------
package xtea128_pkg;

    localparam logic [31:0] XTEA_DELTA = 32'h9E3779B9;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // four 32-bit words, word 0 in bits 31:0
    typedef logic [3:0][31:0] t_block;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic        first_block;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_beat;

    typedef enum logic [2:0] {
        CFG_KEY_LOW     = 3'd0,
        CFG_KEY_HIGH    = 3'd1,
        CFG_IV_LOW      = 3'd2,
        CFG_IV_HIGH     = 3'd3,
        CFG_ROUND_COUNT = 3'd4,
        CFG_CHAIN_MODE  = 3'd5,
        CFG_DIRECTION   = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_ECB  = 3'd0,
        MODE_CBC  = 3'd1,
        MODE_PCBC = 3'd2,
        MODE_CFB  = 3'd3,
        MODE_OFB  = 3'd4
    } t_mode;

    typedef struct packed {
        t_block      key;
        t_block      iv;
        logic [7:0]  round_count;
        logic [2:0]  chain_mode;
        logic        direction;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH
    } t_state;

endpackage
`default_nettype wire

/* src/xtea128_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// xtea128_cfg_regs
// Configuration register file: key, IV, round count, chaining mode, direction.
// ----------------------------------------------------------------------------
module xtea128_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [xtea128_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [xtea128_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output xtea128_pkg::t_cfg                       o_cfg
);
    import xtea128_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key         <= '0;
            r_cfg.iv          <= '0;
            r_cfg.round_count <= 8'd32;
            r_cfg.chain_mode  <= MODE_ECB;
            r_cfg.direction   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KEY_LOW:     r_cfg.key[1:0]      <= i_cfg_data;
                CFG_KEY_HIGH:    r_cfg.key[3:2]      <= i_cfg_data;
                CFG_IV_LOW:      r_cfg.iv[1:0]       <= i_cfg_data;
                CFG_IV_HIGH:     r_cfg.iv[3:2]       <= i_cfg_data;
                CFG_ROUND_COUNT: r_cfg.round_count   <= i_cfg_data[7:0];
                CFG_CHAIN_MODE:  r_cfg.chain_mode    <= i_cfg_data[2:0];
                CFG_DIRECTION:   r_cfg.direction     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* src/xtea128_round_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// xtea128_round_unit
// One full Feistel round (two word updates and word rotation), either way.
// ----------------------------------------------------------------------------
module xtea128_round_unit (
    input  wire xtea128_pkg::t_block i_w,
    input  wire logic [31:0]         i_sum,
    input  wire logic                i_dec,
    input  wire xtea128_pkg::t_block i_key,
    output xtea128_pkg::t_block      o_w,
    output logic [31:0]              o_sum
);
    import xtea128_pkg::*;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] d;
        d = {x, x} << s;
        return d[63:32];
    endfunction

    function automatic logic [31:0] mix(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] s, input logic [31:0] k);
        return ((a << 4) ^ (a >> 5)) + (b ^ s) + rotl(k, a[4:0]);
    endfunction

    logic [31:0] enc_s1;
    logic [31:0] dec_s1;
    t_block      rot;
    t_block      enc_w;
    t_block      dec_w;

    always_comb begin
        enc_s1   = i_sum + XTEA_DELTA;
        enc_w[0] = i_w[1];
        enc_w[1] = i_w[2] + mix(i_w[3], i_w[1], enc_s1, i_key[enc_s1[12:11]]);
        enc_w[2] = i_w[3];
        enc_w[3] = i_w[0] + mix(i_w[1], i_w[3], i_sum, i_key[i_sum[1:0]]);

        rot[0]   = i_w[3];
        rot[1]   = i_w[0];
        rot[2]   = i_w[1];
        rot[3]   = i_w[2];
        dec_s1   = i_sum - XTEA_DELTA;
        dec_w[0] = rot[0] - mix(rot[1], rot[3], dec_s1, i_key[dec_s1[1:0]]);
        dec_w[1] = rot[1];
        dec_w[2] = rot[2] - mix(rot[3], rot[1], i_sum, i_key[i_sum[12:11]]);
        dec_w[3] = rot[3];

        o_w   = i_dec ? dec_w : enc_w;
        o_sum = i_dec ? dec_s1 : enc_s1;
    end

endmodule
`default_nettype wire

/* src/xtea128_block_cipher_modes_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// xtea128_block_cipher_modes_top
// 128-bit XTEA-style block cipher with ECB, CBC, PCBC, CFB and OFB chaining.
//
//   channel  signals                               beat
//   cfg      i_cfg_valid / o_cfg_ready            i_cfg_index, i_cfg_data
//   in       i_in_valid  / o_in_ready             i_in_beat (t_in_beat)
//   out      o_out_valid / i_out_ready            o_out_beat (t_out_beat)
//
// A block passes through accept, load and whitening, the rounds in the
// shared round unit, then a finish cycle for the final whitening and
// chaining. With zero rounds the round state is skipped.
// Reset is synchronous: chain value cleared, round count 32, ECB encrypt.
// A held output beat stalls only the finish cycle; the next block is
// accepted in the cycle after the finish cycle completes.
// ----------------------------------------------------------------------------
module xtea128_block_cipher_modes_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [xtea128_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [xtea128_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire xtea128_pkg::t_in_beat              i_in_beat,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output xtea128_pkg::t_out_beat                  o_out_beat
);
    import xtea128_pkg::*;

    t_cfg        cfg;
    t_state      r_state, n_state;
    t_in_beat    r_in;
    t_block      r_w, n_w;
    t_block      r_chain, n_chain;
    logic [31:0] r_sum, n_sum;
    logic [7:0]  r_left, n_left;
    logic        r_dec, n_dec;
    t_out_beat   r_out, n_out;
    logic        r_out_valid, n_out_valid;

    t_block      rnd_w;
    logic [31:0] rnd_sum;
    logic        in_acc;
    logic        is_stream;
    logic        dir_dec;
    t_block      plain;
    t_block      x;
    t_block      y;
    t_block      res;
    logic [39:0] dec_sum;

    xtea128_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    xtea128_round_unit u_round (
        .i_w   (r_w),
        .i_sum (r_sum),
        .i_dec (r_dec),
        .i_key (cfg.key),
        .o_w   (rnd_w),
        .o_sum (rnd_sum)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_chain     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_chain     <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_beat;
        end
        r_w    <= n_w;
        r_sum  <= n_sum;
        r_left <= n_left;
        r_dec  <= n_dec;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_w         = r_w;
        n_sum       = r_sum;
        n_left      = r_left;
        n_dec       = r_dec;
        n_chain     = r_chain;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        is_stream = (cfg.chain_mode == MODE_CFB) || (cfg.chain_mode == MODE_OFB);
        dir_dec   = cfg.direction && !is_stream;
        plain     = {r_in.block_high, r_in.block_low};
        dec_sum   = XTEA_DELTA * cfg.round_count;

        // cipher input and leading whitening
        if (is_stream) begin
            x = r_chain;
        end else if (!cfg.direction &&
                     (cfg.chain_mode == MODE_CBC || cfg.chain_mode == MODE_PCBC)) begin
            x = plain ^ r_chain;
        end else begin
            x = plain;
        end
        if (dir_dec) begin
            x[0] = x[0] ^ cfg.key[2];
            x[2] = x[2] ^ cfg.key[3];
        end else begin
            x[1] = x[1] + cfg.key[0];
            x[3] = x[3] + cfg.key[1];
        end

        // trailing whitening
        y = r_w;
        if (r_dec) begin
            y[1] = r_w[1] - cfg.key[0];
            y[3] = r_w[3] - cfg.key[1];
        end else begin
            y[0] = r_w[0] ^ cfg.key[2];
            y[2] = r_w[2] ^ cfg.key[3];
        end

        case (cfg.chain_mode)
            MODE_CBC, MODE_PCBC: res = cfg.direction ? (y ^ r_chain) : y;
            MODE_CFB, MODE_OFB:  res = plain ^ y;
            default:             res = y;
        endcase

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_beat.first_block) begin
                        n_chain = cfg.iv;
                    end
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_w    = x;
                n_dec  = dir_dec;
                n_sum  = dir_dec ? dec_sum[31:0] : '0;
                n_left = cfg.round_count;
                n_state = (cfg.round_count == 8'd0) ? ST_FINISH : ST_ROUND;
            end
            ST_ROUND: begin
                n_w    = rnd_w;
                n_sum  = rnd_sum;
                n_left = r_left - 8'd1;
                if (r_left == 8'd1) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out.result_low  = {res[1], res[0]};
                    n_out.result_high = {res[3], res[2]};
                    n_out_valid       = 1'b1;
                    n_state           = ST_IDLE;
                    case (cfg.chain_mode)
                        MODE_CBC:  n_chain = cfg.direction ? plain : y;
                        MODE_PCBC: n_chain = res ^ plain;
                        MODE_CFB:  n_chain = cfg.direction ? plain : res;
                        MODE_OFB:  n_chain = y;
                        default:   n_chain = r_chain;
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
